FILE: rtl/seven_segment_serial_display_driver_assert.svh
// ---------------------------------------------------------------------------
// Seven-segment serial display driver assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define SSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ssd: assertion failed");
// Checked at every edge, reset included.
`define SSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ssd: assertion failed");
`else
`define SSD_ASSERT(lbl, prop)
`define SSD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/ssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment serial display driver package
// Segment tables and the reciprocal constants for the decimal digit split.
// ---------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned CntBits  = $clog2(WordBits);
  localparam int unsigned OutBytes = 8;

  // floor(v / d) == (v * Mul) >> Shift for every 16-bit v.
  localparam logic [15:0] Mul10     = 16'd52429;
  localparam int unsigned Shift10   = 19;
  localparam logic [16:0] Mul100    = 17'd83887;
  localparam int unsigned Shift100  = 23;
  localparam logic [16:0] Mul1000   = 17'd67109;
  localparam int unsigned Shift1000 = 26;

  typedef logic [3:0] digit_t;
  typedef logic [WordBits-1:0] word_t;

  // Pattern in the PCDE--------GFAB layout of displays 1 and 3.
  function automatic logic [15:0] seg_outer(input digit_t d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Pattern of display 2, already placed at word bits 11..4.
  function automatic logic [15:0] seg_middle(input digit_t d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Low four bits of q * 10; enough to recover a digit that lies in 0..9.
  function automatic digit_t times10_lo(input digit_t q);
    return digit_t'({q[2:0], 1'b0} + {q[0], 3'b000});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/seven_segment_serial_display_driver.sv
// ---------------------------------------------------------------------------
// Seven-segment serial display driver
// The first bit of a word is offered once the word has passed the input
// register, then the quotient register, then the shifter.
// Throughput: one output beat per cycle while m_axis_tready_i is high, set by
// the bit shifter; two more input words are buffered ahead of it.
// Reset clears all valid flags; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_serial_display_driver_assert.svh"

module seven_segment_serial_display_driver
  import ssd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  input  wire logic [WordBits-1:0]   s_axis_tdata_i,  // [31:0] value
  input  wire logic                  s_axis_tuser_i,  // [0] mode
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output      logic [OutBytes-1:0]   m_axis_tdata_o,  // [0] serial_data, [5:1] bit_number
  output      logic                  m_axis_tlast_o   // latch_and_last
);

  // Input register.
  logic                s1_vld_q, s1_vld_d;
  logic                s1_mode_q;
  word_t               s1_value_q;

  // Quotient register.
  logic                s2_vld_q, s2_vld_d;
  logic                s2_mode_q;
  word_t               s2_value_q;
  logic [12:0]         s2_q10_q;
  logic [9:0]          s2_q100_q;
  logic [6:0]          s2_q1000_q;

  // Bit shifter.
  logic                sh_vld_q, sh_vld_d;
  word_t               sh_word_q, sh_word_d;
  logic [CntBits-1:0]  sh_cnt_q, sh_cnt_d;

  logic                out_fire, out_last, load, s2_adv, s1_adv;
  logic [31:0]         prod10;
  logic [32:0]         prod100, prod1000;
  digit_t              dig_ones, dig_tens, dig_hund;
  word_t               dec_word, word_d;

  assign out_last = (sh_cnt_q == CntBits'(WordBits - 1));
  assign out_fire = sh_vld_q && m_axis_tready_i;
  assign load     = s2_vld_q && (!sh_vld_q || (out_fire && out_last));
  assign s2_adv   = !s2_vld_q || load;
  assign s1_adv   = !s1_vld_q || s2_adv;

  assign s_axis_tready_o = s1_adv;
  assign s1_vld_d = s1_adv ? s_axis_tvalid_i : s1_vld_q;
  assign s2_vld_d = s2_adv ? s1_vld_q : s2_vld_q;

  // Reciprocal multiplications for v/10, v/100 and v/1000.
  assign prod10   = 32'(s1_value_q[15:0]) * 32'(Mul10);
  assign prod100  = 33'(s1_value_q[15:0]) * 33'(Mul100);
  assign prod1000 = 33'(s1_value_q[15:0]) * 33'(Mul1000);

  // Each digit is a quotient minus ten times the next quotient.
  assign dig_ones = s2_value_q[3:0] - times10_lo(s2_q10_q[3:0]);
  assign dig_tens = s2_q10_q[3:0]   - times10_lo(s2_q100_q[3:0]);
  assign dig_hund = s2_q100_q[3:0]  - times10_lo(s2_q1000_q[3:0]);

  assign dec_word = {seg_outer(dig_hund), 16'h0000}
                  | {16'h0000, seg_middle(dig_tens)}
                  | {16'h0000, seg_outer(dig_ones)};
  assign word_d   = s2_mode_q ? s2_value_q : dec_word;

  always_comb begin
    sh_vld_d  = sh_vld_q;
    sh_word_d = sh_word_q;
    sh_cnt_d  = sh_cnt_q;
    if (load) begin
      sh_vld_d  = 1'b1;
      sh_word_d = word_d;
      sh_cnt_d  = '0;
    end else if (out_fire) begin
      sh_vld_d  = !out_last;
      sh_word_d = sh_word_q >> 1;
      sh_cnt_d  = sh_cnt_q + CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sh_vld_q <= 1'b0;
      sh_cnt_q <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      sh_vld_q <= sh_vld_d;
      sh_cnt_q <= sh_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_mode_q  <= s_axis_tuser_i;
      s1_value_q <= s_axis_tdata_i;
    end
    if (s2_adv) begin
      s2_mode_q  <= s1_mode_q;
      s2_value_q <= s1_value_q;
      s2_q10_q   <= prod10[Shift10 +: 13];
      s2_q100_q  <= prod100[Shift100 +: 10];
      s2_q1000_q <= prod1000[Shift1000 +: 7];
    end
    sh_word_q <= sh_word_d;
  end

  assign m_axis_tvalid_o = sh_vld_q;
  assign m_axis_tdata_o  = {{(OutBytes - 1 - CntBits){1'b0}}, sh_cnt_q, sh_word_q[0]};
  assign m_axis_tlast_o  = out_last;

  // The input only stalls when both buffer stages hold a word.
  `SSD_ASSERT(a_stall_full, !s_axis_tready_o |-> s1_vld_q && s2_vld_q)
  // Within a word, bit numbers step by one with no gap.
  `SSD_ASSERT(a_bit_step,
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tdata_o[5:1] == $past(m_axis_tdata_o[5:1]) + 5'd1))
  // A word that fills the shifter starts at bit zero.
  `SSD_ASSERT(a_load_start, load |=> sh_cnt_q == '0)
  // An edge seen in reset leaves the block idle by the next edge.
  `SSD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o && s_axis_tready_o)

endmodule

`default_nettype wire
